FILE: hw/rtl/x86_alu_with_flags_top_macros.svh
// Assertion macros for the x86 integer ALU block.
// Included by the top level; no other dependencies.
`ifndef X86_ALU_WITH_FLAGS_TOP_MACROS_SVH
`define X86_ALU_WITH_FLAGS_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent in this cycle implies consequent in the same cycle.
`define X86ALU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define X86ALU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define X86ALU_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define X86ALU_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/x86alu_pkg.sv
// Shared types and constants for the x86 integer ALU block.
// No dependencies; used by the execution core and the top level.
package x86alu_pkg;

   localparam int unsigned DataBits = 32;

   // Operation codes carried on the request tuser.
   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_OR   = 4'd1,
      OP_ADC  = 4'd2,
      OP_SBB  = 4'd3,
      OP_AND  = 4'd4,
      OP_SUB  = 4'd5,
      OP_XOR  = 4'd6,
      OP_CMP  = 4'd7,
      OP_TEST = 4'd8,
      OP_SHL  = 4'd9,
      OP_SHR  = 4'd10
   } operation_type;

   // Operand width codes; the unused code behaves as doubleword.
   typedef enum logic [1:0] {
      WIDTH_BYTE  = 2'd0,
      WIDTH_WORD  = 2'd1,
      WIDTH_DWORD = 2'd2
   } width_type;

   // Status flags, carry in the lowest bit.
   typedef struct packed {
      logic overflow;
      logic sign;
      logic zero;
      logic carry;
   } flags_type;

endpackage

FILE: hw/rtl/x86_alu_with_flags_top.sv
// Top level of the x86 integer ALU: input register, execution core, flag
// register and result register. Depends on x86alu_pkg, x86alu_core and the
// assertion macro header.
`include "x86_alu_with_flags_top_macros.svh"

// One ALU operation is accepted per clock cycle unless the result stalls: a
// request is captured in the input register, runs through the execution core
// and is captured with its flags in the result register. The status flag
// register is written at the same edge as the result register, so adc and sbb
// see the carry of the operation immediately ahead of them with no bubble. A
// stalled result holds the result register, and the input register keeps
// taking a transaction as long as the stage ahead of it can move.
module x86_alu_with_flags_top import x86alu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // lhs_value [31:0], rhs_value [63:32]
   input  logic [63:0] req_tdata,
   // operation [3:0], width [5:4]
   input  logic [5:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_value [31:0], carry_flag [32], zero_flag [33], sign_flag [34],
   // overflow_flag [35], zero padding [39:36]
   output logic [39:0] rsp_tdata,
   // write_back [0]
   output logic        rsp_tuser
);

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [3:0]          s1_op_ff;
   logic [1:0]          s1_width_ff;
   logic [DataBits-1:0] s1_lhs_ff;
   logic [DataBits-1:0] s1_rhs_ff;
   logic                req_take;
   logic                out_free;
   logic                s1_move;

   flags_type           flags_ff;
   flags_type           flags_in;
   flags_type           core_flags;
   logic [DataBits-1:0] core_result;
   logic                core_wb;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [39:0]         rsp_data_ff;
   logic                rsp_wb_ff;

   // Handshake: the result register frees when empty or taken.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_tready);
   assign flags_in     = s1_move ? core_flags : flags_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= req_tuser[3:0];
         s1_width_ff <= req_tuser[5:4];
         s1_lhs_ff   <= req_tdata[31:0];
         s1_rhs_ff   <= req_tdata[63:32];
      end
   end

   x86alu_core u_core (
      .operation    (s1_op_ff),
      .width        (s1_width_ff),
      .lhs_value    (s1_lhs_ff),
      .rhs_value    (s1_rhs_ff),
      .flags_cur    (flags_ff),
      .result_value (core_result),
      .write_back   (core_wb),
      .flags_nxt    (core_flags)
   );

   // Result register payload.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= {4'b0000, core_flags.overflow, core_flags.sign,
                         core_flags.zero, core_flags.carry, core_result};
         rsp_wb_ff   <= core_wb;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_wb_ff;

   // The flags shown with a fresh result are the stored flag state.
   `X86ALU_ASSERT_NEXT(a_flags_match, clock, reset, s1_move,
      rsp_data_ff[35:32] == flags_ff, "result flags differ from flag state")
   // Compare and test never write back.
   `X86ALU_ASSERT_NEXT(a_no_wb_cmp, clock, reset,
      s1_move && ((s1_op_ff == OP_CMP) || (s1_op_ff == OP_TEST)),
      !rsp_wb_ff, "compare or test marked for write-back")
   // Logic operations clear carry and overflow.
   `X86ALU_ASSERT_NEXT(a_logic_flags, clock, reset,
      s1_move && ((s1_op_ff == OP_OR) || (s1_op_ff == OP_AND) ||
                  (s1_op_ff == OP_XOR) || (s1_op_ff == OP_TEST)),
      !flags_ff.carry && !flags_ff.overflow, "logic operation left carry or overflow")
   // Unknown operation codes leave the flag state untouched.
   `X86ALU_ASSERT_NEXT(a_noop_flags, clock, reset,
      s1_move && (s1_op_ff > OP_SHR), $stable(flags_ff), "no-op changed the flags")
   // Flags only move when a transaction leaves the input register.
   `X86ALU_ASSERT_SAME(a_flags_hold, clock, reset, !s1_move,
      flags_in == flags_ff, "flag state changes without an operation")

endmodule

FILE: hw/rtl/x86alu_core.sv
// Combinational execution core: one ALU operation with x86 flag rules.
// Depends on x86alu_pkg for operation, width and flag types.
module x86alu_core import x86alu_pkg::*; (
   input  logic [3:0]          operation,
   input  logic [1:0]          width,
   input  logic [DataBits-1:0] lhs_value,
   input  logic [DataBits-1:0] rhs_value,
   input  flags_type           flags_cur,
   output logic [DataBits-1:0] result_value,
   output logic                write_back,
   output flags_type           flags_nxt
);

   logic [DataBits-1:0] mask;
   logic [DataBits-1:0] a;
   logic [DataBits-1:0] b;
   logic [DataBits:0]   sum;
   logic [DataBits:0]   diff;
   logic [DataBits:0]   shl_wide;
   logic [DataBits:0]   shr_wide;
   logic [4:0]          count;
   logic                cin;
   logic [DataBits-1:0] res;
   logic                cf;
   logic                of;
   logic                update;

   // Pick the top bit of a value at the operand width.
   function automatic logic top_bit(input logic [DataBits-1:0] v, input logic [1:0] w);
      logic bit_out;
      case (w)
         WIDTH_BYTE: bit_out = v[7];
         WIDTH_WORD: bit_out = v[15];
         default:    bit_out = v[31];
      endcase
      return bit_out;
   endfunction

   // Pick the bit just above the operand width.
   function automatic logic out_bit(input logic [DataBits:0] v, input logic [1:0] w);
      logic bit_out;
      case (w)
         WIDTH_BYTE: bit_out = v[8];
         WIDTH_WORD: bit_out = v[16];
         default:    bit_out = v[32];
      endcase
      return bit_out;
   endfunction

   // Operand masking by width.
   always_comb begin
      case (width)
         WIDTH_BYTE: mask = 32'h0000_00ff;
         WIDTH_WORD: mask = 32'h0000_ffff;
         default:    mask = 32'hffff_ffff;
      endcase
   end

   assign a     = lhs_value & mask;
   assign b     = rhs_value & mask;
   assign count = rhs_value[4:0];
   assign cin   = flags_cur.carry &&
                  ((operation == OP_ADC) || (operation == OP_SBB));

   // Shared datapath pieces: adder, subtractor and the two shifters.
   assign sum      = {1'b0, a} + {1'b0, b} + {{DataBits{1'b0}}, cin};
   assign diff     = {1'b0, a} - {1'b0, b} - {{DataBits{1'b0}}, cin};
   assign shl_wide = {1'b0, a} << count;
   assign shr_wide = {a, 1'b0} >> count;

   // Operation select and flag rules.
   always_comb begin
      res        = a;
      write_back = 1'b1;
      cf         = 1'b0;
      of         = 1'b0;
      update     = 1'b1;
      case (operation_type'(operation))
         OP_ADD, OP_ADC: begin
            res = sum[DataBits-1:0] & mask;
            cf  = out_bit(sum, width);
            of  = top_bit(~(a ^ b) & (a ^ res), width);
         end
         OP_SUB, OP_SBB, OP_CMP: begin
            res        = diff[DataBits-1:0] & mask;
            cf         = diff[DataBits];
            of         = top_bit((a ^ b) & (a ^ res), width);
            write_back = (operation != OP_CMP);
         end
         OP_OR:  res = a | b;
         OP_AND: res = a & b;
         OP_XOR: res = a ^ b;
         OP_TEST: begin
            res        = a & b;
            write_back = 1'b0;
         end
         OP_SHL: begin
            res    = shl_wide[DataBits-1:0] & mask;
            cf     = out_bit(shl_wide, width);
            of     = top_bit(res, width) ^ out_bit(shl_wide, width);
            update = (count != 5'd0);
         end
         OP_SHR: begin
            res    = shr_wide[DataBits:1];
            cf     = shr_wide[0];
            of     = top_bit(a, width);
            update = (count != 5'd0);
         end
         default: begin
            write_back = 1'b0;
            update     = 1'b0;
         end
      endcase
   end

   // New flag state; unchanged where the operation leaves the flags alone.
   always_comb begin
      if (update) begin
         flags_nxt.carry    = cf;
         flags_nxt.zero     = (res == '0);
         flags_nxt.sign     = top_bit(res, width);
         flags_nxt.overflow = of;
      end else begin
         flags_nxt = flags_cur;
      end
   end

   assign result_value = res;

endmodule

FILE: tb/tb_x86_alu_with_flags_top.sv
// Self-checking testbench for the x86 integer ALU: streams directed and random
// operations with random idling on both sides and checks every result and flag.
// Depends on x86alu_pkg and x86_alu_with_flags_top.
module tb_x86_alu_with_flags_top;
   import x86alu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          ClockHalf   = 6;
   localparam int          ResetCycles = 9;
   localparam int          RandomOps   = 500;
   localparam int          DrainCycles = 10;
   localparam int          CycleLimit  = 400000;
   // Codes that the package leaves unnamed: the spare width and the no-op range.
   localparam logic [1:0]  WIDTH_SPARE    = 2'd3;
   localparam logic [3:0]  OP_FIRST_SPARE = 4'd11;
   localparam logic [3:0]  OP_LAST_SPARE  = 4'd15;

   // One operation as it is sent to the block.
   typedef struct {
      logic [3:0]  operation;
      logic [1:0]  width;
      logic [31:0] lhs;
      logic [31:0] rhs;
   } alu_op_type;

   // One result as it should come back.
   typedef struct {
      logic [31:0] result_value;
      logic        write_back;
      flags_type   flags;
   } alu_outcome_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [5:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;

   alu_op_type      pending_ops[$];
   alu_outcome_type expected_outcomes[$];
   flags_type    flag_state    = '0;
   int           accepted_count = 0;
   int           op_total       = 0;
   int           fail_count     = 0;
   int           cycle_count    = 0;
   int           send_gap       = 0;
   int           stall_left     = 0;
   bit           send_quiet     = 1'b0;
   bit           recv_quiet     = 1'b0;

   x86_alu_with_flags_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(ClockHalf) clock = ~clock;

   // Executes one operation on the local copy of the status flags and returns
   // what the block should answer.
   function automatic alu_outcome_type execute_alu(input logic [3:0] op,
                                                   input logic [1:0] wsel,
                                                   input logic [31:0] lhs,
                                                   input logic [31:0] rhs);
      alu_outcome_type outcome;
      int unsigned  nbits;
      int unsigned  count;
      logic [63:0]  mask;
      logic [63:0]  top;
      logic [63:0]  a;
      logic [63:0]  b;
      logic [63:0]  cin;
      logic [63:0]  subtrahend;
      logic [63:0]  r;
      logic         cf;
      logic         of;
      logic         wb;
      logic         update;
      case (wsel)
         WIDTH_BYTE: nbits = 8;
         WIDTH_WORD: nbits = 16;
         default:    nbits = 32;
      endcase
      mask   = (64'd1 << nbits) - 64'd1;
      top    = 64'd1 << (nbits - 1);
      a      = {32'd0, lhs} & mask;
      b      = {32'd0, rhs} & mask;
      cin    = {63'd0, flag_state.carry};
      r      = a;
      cf     = 1'b0;
      of     = 1'b0;
      wb     = 1'b1;
      update = 1'b1;
      case (op)
         OP_ADD, OP_ADC: begin
            r  = a + b + ((op == OP_ADC) ? cin : 64'd0);
            cf = (r >> nbits) != 0;
            r  = r & mask;
            of = ((~(a ^ b)) & (a ^ r) & top) != 0;
         end
         OP_SUB, OP_SBB, OP_CMP: begin
            subtrahend = b + ((op == OP_SBB) ? cin : 64'd0);
            cf = a < subtrahend;
            r  = (a - subtrahend) & mask;
            of = ((a ^ b) & (a ^ r) & top) != 0;
            wb = (op != OP_CMP);
         end
         OP_OR:  r = a | b;
         OP_AND: r = a & b;
         OP_XOR: r = a ^ b;
         OP_TEST: begin
            r  = a & b;
            wb = 1'b0;
         end
         OP_SHL, OP_SHR: begin
            count = 32'(rhs[4:0]);
            if (count == 0) begin
               // A zero count leaves every flag as it was.
               update = 1'b0;
            end else if (op == OP_SHL) begin
               r  = (a << count) & mask;
               cf = (count <= nbits) ? a[nbits - count] : 1'b0;
               of = ((r & top) != 0) != cf;
            end else begin
               r  = a >> count;
               cf = (count <= nbits) ? a[count - 1] : 1'b0;
               of = (a & top) != 0;
            end
         end
         default: begin
            // Unassigned operation codes do nothing at all.
            wb     = 1'b0;
            update = 1'b0;
         end
      endcase
      if (update) begin
         flag_state.carry    = cf;
         flag_state.zero     = (r == 0);
         flag_state.sign     = (r & top) != 0;
         flag_state.overflow = of;
      end
      outcome.result_value = r[31:0];
      outcome.write_back   = wb;
      outcome.flags        = flag_state;
      return outcome;
   endfunction

   // Idle length: none in a quiet stretch, otherwise mostly short and now and
   // then long.
   function automatic int idle_length(input bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Operand value: either a boundary value or a fully random word.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 19))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h0000_007F;
         3:       return 32'h0000_0080;
         4:       return 32'h0000_7FFF;
         5:       return 32'h0000_8000;
         6:       return 32'h7FFF_FFFF;
         7:       return 32'h8000_0000;
         8:       return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_op(input logic [3:0] op, input logic [1:0] wsel,
                           input logic [31:0] lhs, input logic [31:0] rhs);
      alu_op_type item;
      item.operation = op;
      item.width     = wsel;
      item.lhs       = lhs;
      item.rhs       = rhs;
      pending_ops.push_back(item);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Request driver: presents queued operations and predicts each one as its
   // transaction is accepted.
   always @(posedge clock) begin
      alu_op_type next_op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(execute_alu(req_tuser[3:0], req_tuser[5:4],
                                                    req_tdata[31:0], req_tdata[63:32]));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0 || pending_ops.size() == 0) begin
               if (send_gap != 0) begin
                  send_gap--;
               end
               req_tvalid <= 1'b0;
            end else begin
               next_op = pending_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {next_op.rhs, next_op.lhs};
               req_tuser  <= {next_op.width, next_op.operation};
               if ($urandom_range(0, 39) == 0) begin
                  send_quiet = !send_quiet;
               end
               send_gap = idle_length(send_quiet);
            end
         end
      end
   end

   // Result monitor: compares each accepted transaction with the oldest
   // prediction and stalls the result channel at random.
   always @(posedge clock) begin
      alu_outcome_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outcomes.size() == 0) begin
               $error("result transaction arrived with no operation outstanding");
               fail_count++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("result_value", want.result_value, rsp_tdata[31:0]);
               check_field("write_back", 32'(want.write_back), 32'(rsp_tuser));
               check_field("carry_flag", 32'(want.flags.carry), 32'(rsp_tdata[32]));
               check_field("zero_flag", 32'(want.flags.zero), 32'(rsp_tdata[33]));
               check_field("sign_flag", 32'(want.flags.sign), 32'(rsp_tdata[34]));
               check_field("overflow_flag", 32'(want.flags.overflow),
                           32'(rsp_tdata[35]));
            end
         end
         if ($urandom_range(0, 49) == 0) begin
            recv_quiet = !recv_quiet;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = idle_length(recv_quiet);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [3:0]  op;
      logic [1:0]  wsel;
      logic [31:0] rhs;

      // Carry chains through adc and sbb, with wrap to zero and sign changes.
      queue_op(OP_ADD, WIDTH_BYTE, 32'hFFFF_FFFF, 32'h0000_0001);
      queue_op(OP_ADC, WIDTH_BYTE, 32'h1234_567F, 32'h0000_0000);
      queue_op(OP_ADD, WIDTH_DWORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(OP_ADC, WIDTH_WORD, 32'h0000_FFFF, 32'hABCD_FFFF);
      queue_op(OP_SUB, WIDTH_DWORD, 32'h0000_0000, 32'h0000_0001);
      queue_op(OP_SBB, WIDTH_BYTE, 32'h0000_0080, 32'h0000_0000);
      queue_op(OP_SUB, WIDTH_BYTE, 32'h0000_0000, 32'h0000_0001);
      // Borrow with the stored carry pushing the subtrahend past the width.
      queue_op(OP_SBB, WIDTH_BYTE, 32'h0000_0000, 32'h0000_00FF);
      queue_op(OP_CMP, WIDTH_DWORD, 32'h8000_0000, 32'h0000_0001);
      // Logic operations clear carry and overflow; upper bits must be ignored.
      queue_op(OP_OR, WIDTH_WORD, 32'hDEAD_8001, 32'hFFFF_0000);
      queue_op(OP_AND, WIDTH_WORD, 32'hDEAD_8001, 32'h0000_7FFE);
      queue_op(OP_XOR, WIDTH_DWORD, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      queue_op(OP_TEST, WIDTH_BYTE, 32'h0000_0080, 32'h0000_00FF);
      // Shifts: a masked count of zero, counts at and past the width.
      queue_op(OP_SUB, WIDTH_BYTE, 32'h0000_0000, 32'h0000_0001);
      queue_op(OP_SHL, WIDTH_BYTE, 32'h0000_00A5, 32'hFFFF_FFE0);
      queue_op(OP_SHL, WIDTH_BYTE, 32'h0000_0001, 32'h0000_0008);
      queue_op(OP_SHL, WIDTH_BYTE, 32'h0000_00FF, 32'h0000_0009);
      queue_op(OP_SHL, WIDTH_DWORD, 32'h4000_0000, 32'h0000_0001);
      queue_op(OP_SHL, WIDTH_DWORD, 32'h0000_0003, 32'h0000_001F);
      queue_op(OP_SHR, WIDTH_DWORD, 32'h8000_0001, 32'h0000_0001);
      queue_op(OP_SHR, WIDTH_DWORD, 32'hC000_0000, 32'h0000_001F);
      queue_op(OP_SHR, WIDTH_BYTE, 32'h0000_0080, 32'h0000_0008);
      queue_op(OP_SHR, WIDTH_BYTE, 32'h0000_00FF, 32'h0000_000C);
      // The spare width code and the unassigned operation codes.
      queue_op(OP_ADD, WIDTH_SPARE, 32'h7FFF_FFFF, 32'h0000_0001);
      queue_op(OP_FIRST_SPARE, WIDTH_WORD, 32'h1234_5678, 32'h0000_0001);
      queue_op(OP_LAST_SPARE, WIDTH_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Random operations, mostly assigned codes at the three real widths.
      for (int i = 0; i < RandomOps; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            op = 4'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE));
         end else begin
            op = 4'($urandom_range(OP_ADD, OP_SHR));
         end
         if ($urandom_range(0, 15) == 0) begin
            wsel = WIDTH_SPARE;
         end else begin
            wsel = 2'($urandom_range(WIDTH_BYTE, WIDTH_DWORD));
         end
         rhs = pick_operand();
         if ((op == OP_SHL || op == OP_SHR) && $urandom_range(0, 3) == 0) begin
            // Favour counts up to just past the byte width.
            rhs[4:0] = 5'($urandom_range(0, 9));
         end
         queue_op(op, wsel, pick_operand(), rhs);
      end
      op_total = pending_ops.size();

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != op_total) @(posedge clock);
      while (expected_outcomes.size() != 0) @(posedge clock);
      // Let any stray result surface before the verdict.
      repeat (DrainCycles) @(posedge clock);

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
